>>> sv/utf16_to_utf8_converter_core_assert.svh
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 converter assertion macros
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_CONVERTER_CORE_ASSERT_SVH
`define UTF16_TO_UTF8_CONVERTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U16U8_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U16U8_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 converter package
// Shared types, constants and the BMP encoding function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

   localparam int unsigned MaxBytes = 6;

   localparam logic [15:0] HighSurrFirst = 16'hD800;
   localparam logic [15:0] HighSurrLast  = 16'hDBFF;
   localparam logic [15:0] LowSurrFirst  = 16'hDC00;
   localparam logic [15:0] LowSurrLast   = 16'hDFFF;
   localparam logic [15:0] OneByteMax    = 16'h007F;
   localparam logic [15:0] TwoByteMax    = 16'h07FF;
   localparam logic [20:0] SuppBase      = 21'h10000;

   localparam logic [7:0] Lead2 = 8'hC0;
   localparam logic [7:0] Lead3 = 8'hE0;
   localparam logic [7:0] Lead4 = 8'hF0;
   localparam logic [7:0] Cont  = 8'h80;

   typedef logic [MaxBytes-1:0][7:0] byte_list_type;

   // Up to three bytes of one BMP unit, first byte in slot 0.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
   } bmp_code_type;

   // Everything one accepted item produces, plus the next surrogate state.
   typedef struct packed {
      byte_list_type bytes;
      logic [2:0]    count;
      logic          hold;
      logic [15:0]   held;
   } enc_result_type;

   function automatic bmp_code_type bmp_encode(input logic [15:0] u);
      bmp_code_type r;
      r.bytes = '0;
      if (u <= OneByteMax) begin
         r.bytes[0] = u[7:0];
         r.count    = 2'd1;
      end else if (u <= TwoByteMax) begin
         r.bytes[0] = Lead2 | {3'b000, u[10:6]};
         r.bytes[1] = Cont | {2'b00, u[5:0]};
         r.count    = 2'd2;
      end else begin
         r.bytes[0] = Lead3 | {4'b0000, u[15:12]};
         r.bytes[1] = Cont | {2'b00, u[11:6]};
         r.bytes[2] = Cont | {2'b00, u[5:0]};
         r.count    = 2'd3;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/utf16_to_utf8_converter_core.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 converter core
// Converts a stream of UTF-16BE code units into a stream of UTF-8 bytes.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries one code unit per item in req_tdata and marks the
// final unit of a message with req_tlast. The rsp_ channel returns one UTF-8
// byte per item; rsp_tlast marks the last byte caused by one request item and
// rsp_tuser marks the final byte of the whole message. csr_wr_en writes the
// byte-mode bit, which must only change while the block is idle.
// Each accepted item is encoded in the accept cycle and loaded into a byte
// buffer; its first byte is offered on the rsp_ channel in the next cycle.
// The buffer drains one byte per cycle while the receiver is ready; an item
// loads one to six bytes into it, typically one to four.
// A high surrogate that waits for its partner produces no bytes and frees
// the input at once. The next item is taken in the same cycle as the
// previous item's last byte, so items follow back to back with no gap.
// When the receiver stalls, the current byte holds and req_tready stays low
// until the last buffered byte leaves. Reset empties the buffer, drops any
// held surrogate and returns to UTF-16 mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_converter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] code_unit
   input  wire logic        req_tlast,   // message_last
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] utf8_byte
   output logic             rsp_tlast,   // run_last
   output logic             rsp_tuser,   // [0] message_done
   // Configuration.
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data  // byte_mode
);

   `include "utf16_to_utf8_converter_core_assert.svh"

   logic                          byte_mode_ff;
   logic                          holding_ff, holding_in;
   logic [15:0]                   held_ff, held_in;

   // Byte buffer for the item currently being delivered.
   u16u8_pkg::byte_list_type      bytes_ff, bytes_in;
   logic [2:0]                    count_ff, count_in;
   logic [2:0]                    ptr_ff, ptr_in;
   logic                          last_ff, last_in;
   logic                          valid_ff, valid_in;

   u16u8_pkg::enc_result_type     enc;
   logic                          req_fire;
   logic                          rsp_fire;
   logic                          final_byte;

   u16u8_enc u_enc (
      .byte_mode    (byte_mode_ff),
      .holding      (holding_ff),
      .held         (held_ff),
      .code_unit    (req_tdata),
      .message_last (req_tlast),
      .result       (enc)
   );

   // The buffer frees up when its last byte is taken.
   assign final_byte = (ptr_ff == (count_ff - 3'd1));
   assign req_tready = !valid_ff || (rsp_tready && final_byte);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = valid_ff && rsp_tready;

   always_comb begin
      holding_in = holding_ff;
      held_in    = held_ff;
      bytes_in   = bytes_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      last_in    = last_ff;
      valid_in   = valid_ff;

      if (rsp_fire) begin
         if (final_byte) begin
            valid_in = 1'b0;
         end else begin
            ptr_in = ptr_ff + 3'd1;
         end
      end

      if (req_fire) begin
         holding_in = enc.hold;
         held_in    = enc.held;
         if (enc.count != 3'd0) begin
            bytes_in = enc.bytes;
            count_in = enc.count;
            ptr_in   = 3'd0;
            last_in  = req_tlast;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_mode_ff <= 1'b0;
         holding_ff   <= 1'b0;
         held_ff      <= '0;
         valid_ff     <= 1'b0;
         ptr_ff       <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            byte_mode_ff <= csr_wr_data;
         end
         holding_ff <= holding_in;
         held_ff    <= held_in;
         valid_ff   <= valid_in;
         ptr_ff     <= ptr_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      last_ff  <= last_in;
   end

   always_comb begin
      case (ptr_ff)
         3'd0:    rsp_tdata = bytes_ff[0];
         3'd1:    rsp_tdata = bytes_ff[1];
         3'd2:    rsp_tdata = bytes_ff[2];
         3'd3:    rsp_tdata = bytes_ff[3];
         3'd4:    rsp_tdata = bytes_ff[4];
         3'd5:    rsp_tdata = bytes_ff[5];
         default: rsp_tdata = '0;
      endcase
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = final_byte;
   assign rsp_tuser  = final_byte && last_ff;

   // The read pointer never runs past the bytes that were loaded.
   `U16U8_ASSERT_NOW(a_ptr_in_range, valid_ff, ptr_ff < count_ff, "byte pointer out of range")
   // A loaded buffer always holds at least one byte.
   `U16U8_ASSERT_NOW(a_count_nonzero, valid_ff, count_ff != 3'd0, "empty buffer marked valid")
   // A new item is only taken over a busy buffer when its last byte leaves.
   `U16U8_ASSERT_NOW(a_no_overrun, req_fire && valid_ff, rsp_fire && final_byte,
      "item accepted while bytes remain")
   // Only a high surrogate is ever held.
   `U16U8_ASSERT_NOW(a_held_is_high, holding_ff, held_ff[15:10] == 6'b110110,
      "held unit is not a high surrogate")
   // A held surrogate is released by the next accepted item.
   `U16U8_ASSERT_NEXT(a_hold_released, req_fire && holding_ff && !enc.hold, !holding_ff,
      "surrogate still held after release")

endmodule

`default_nettype wire

>>> sv/u16u8_enc.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 item encoder
// Turns one code unit and the held surrogate into up to six UTF-8 bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u16u8_enc (
   input  wire logic                      byte_mode,
   input  wire logic                      holding,
   input  wire logic [15:0]               held,
   input  wire logic [15:0]               code_unit,
   input  wire logic                      message_last,
   output u16u8_pkg::enc_result_type      result
);

   u16u8_pkg::bmp_code_type held_code;
   u16u8_pkg::bmp_code_type unit_code;
   logic                    is_high;
   logic                    is_low;
   logic [20:0]             code_point;
   logic [2:0]              base;

   always_comb begin
      held_code  = u16u8_pkg::bmp_encode(held);
      unit_code  = u16u8_pkg::bmp_encode(code_unit);
      is_high    = (code_unit >= u16u8_pkg::HighSurrFirst) &&
                   (code_unit <= u16u8_pkg::HighSurrLast);
      is_low     = (code_unit >= u16u8_pkg::LowSurrFirst) &&
                   (code_unit <= u16u8_pkg::LowSurrLast);
      code_point = {1'b0, held[9:0], code_unit[9:0]} + u16u8_pkg::SuppBase;
      base       = holding ? 3'd3 : 3'd0;

      result       = '0;
      result.hold  = 1'b0;
      result.held  = '0;

      if (holding) begin
         result.bytes[0] = held_code.bytes[0];
         result.bytes[1] = held_code.bytes[1];
         result.bytes[2] = held_code.bytes[2];
      end

      if (byte_mode) begin
         result.bytes[base] = code_unit[7:0];
         result.count       = base + 3'd1;
      end else if (holding && is_low) begin
         // A surrogate pair becomes one supplementary code point.
         result.bytes[0] = u16u8_pkg::Lead4 | {5'b00000, code_point[20:18]};
         result.bytes[1] = u16u8_pkg::Cont | {2'b00, code_point[17:12]};
         result.bytes[2] = u16u8_pkg::Cont | {2'b00, code_point[11:6]};
         result.bytes[3] = u16u8_pkg::Cont | {2'b00, code_point[5:0]};
         result.count    = 3'd4;
      end else if (is_high && !message_last) begin
         result.hold  = 1'b1;
         result.held  = code_unit;
         result.count = base;
      end else begin
         result.bytes[base]        = unit_code.bytes[0];
         result.bytes[base + 3'd1] = unit_code.bytes[1];
         result.bytes[base + 3'd2] = unit_code.bytes[2];
         result.count              = base + {1'b0, unit_code.count};
      end
   end

endmodule

`default_nettype wire
